>>> rtl/nqd_pkg.sv
// ----------------------------------------------------------------------------
// nqd_pkg: shared types and codes for the node queue dispatcher
// Holds the request kinds, result status codes and the front/back queue entry.
// ----------------------------------------------------------------------------
package nqd_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned TravW   = 4;
  localparam int unsigned NodeW   = 5;
  localparam int unsigned WeightW = 16;
  localparam int unsigned StatusW = 3;

  typedef enum logic [KindW-1:0] {
    KIND_WAIT     = 2'd0,
    KIND_LEAVE    = 2'd1,
    KIND_DISPATCH = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_QUEUED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_GRANTED = 3'd2,
    ST_NONE    = 3'd3,
    ST_LEFT    = 3'd4
  } status_e;

  // Request handed from the front to the back
  typedef struct packed {
    kind_e              kind;
    logic               node_ok;
    logic [TravW-1:0]   traveler;
    logic [NodeW-1:0]   node;
    logic [WeightW-1:0] weight;
  } req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_SCAN,
    BK_SHIFT,
    BK_OUT
  } bk_state_e;

endpackage

>>> rtl/nqd_front.sv
// ----------------------------------------------------------------------------
// nqd_front: request intake and classification
// Accepts stream requests, checks the node range and pushes a short FIFO.
// ----------------------------------------------------------------------------
module nqd_front #(
  parameter int unsigned NODE_COUNT = 32,
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [24:0]        s_tdata_i,
  input  logic [1:0]         s_tuser_i,
  output logic               req_valid_o,
  input  logic               req_pop_i,
  output nqd_pkg::req_t      req_o
);
  import nqd_pkg::*;

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  req_t              fifo_q [FIFO_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     cnt_q;
  req_t              in_req;
  logic              push, pop;

  // Classify the incoming request
  always_comb begin
    in_req.kind     = kind_e'(s_tuser_i);
    in_req.traveler = s_tdata_i[3:0];
    in_req.node     = s_tdata_i[8:4];
    in_req.weight   = s_tdata_i[24:9];
    in_req.node_ok  = ({27'd0, s_tdata_i[8:4]} < 32'(NODE_COUNT));
  end

  assign s_tready_o  = (cnt_q != (PtrW+1)'(FIFO_DEPTH));
  assign push        = s_tvalid_i && s_tready_o;
  assign req_valid_o = (cnt_q != '0);
  assign pop         = req_pop_i && req_valid_o;
  assign req_o       = fifo_q[rd_ptr_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PtrW'(FIFO_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == PtrW'(FIFO_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  // Store request payload
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= in_req;
  end

endmodule

>>> rtl/nqd_back.sv
// ----------------------------------------------------------------------------
// nqd_back: per-node waiting lists and dispatch engine
// Walks one request at a time through list memory: read, scan, shift, reply.
// ----------------------------------------------------------------------------
module nqd_back #(
  parameter int unsigned NODE_COUNT  = 32,
  parameter int unsigned QUEUE_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sched_mode_i,
  input  logic                req_valid_i,
  output logic                req_pop_o,
  input  nqd_pkg::req_t       req_i,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [15:0]         m_tdata_o
);
  import nqd_pkg::*;

  localparam int unsigned NIdxW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned SIdxW = $clog2(QUEUE_SLOTS);
  localparam int unsigned CntW  = $clog2(QUEUE_SLOTS + 1);
  localparam int unsigned AddrW = NIdxW + SIdxW;
  localparam int unsigned Depth = 2 ** AddrW;

  // List memory: id and weight per entry
  logic [TravW+WeightW-1:0] mem_q [Depth];
  logic [TravW+WeightW-1:0] rd_data_q;

  logic [CntW-1:0]  cnt_q [NODE_COUNT];
  logic             occ_q [NODE_COUNT];

  bk_state_e        state_q, state_d;
  req_t             req_q;
  logic [CntW-1:0]  ncnt_q;
  logic [SIdxW-1:0] idx_q, idx_d;
  logic [SIdxW-1:0] best_q, best_d;
  logic [WeightW-1:0] bestw_q, bestw_d;
  logic [TravW-1:0] who_q, who_d;
  logic [StatusW-1:0] st_q, st_d;
  logic             obusy_q;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [TravW+WeightW-1:0] mem_wdata;
  logic             mem_re;
  logic             occ_set, occ_clr, cnt_inc, cnt_dec, out_load;
  logic [NIdxW-1:0] nidx;

  assign nidx = NIdxW'(req_q.node);

  // Next state and control
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    best_d    = best_q;
    bestw_d   = bestw_q;
    who_d     = who_q;
    st_d      = st_q;
    req_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {nidx, idx_q};
    mem_raddr = {nidx, idx_q};
    mem_wdata = {req_q.traveler, req_q.weight};
    occ_set   = 1'b0;
    occ_clr   = 1'b0;
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        req_pop_o = req_valid_i;
        if (req_valid_i) state_d = BK_READ;
      end
      BK_READ: begin
        who_d = req_q.traveler;
        st_d  = ST_NONE;
        idx_d = '0;
        state_d = BK_OUT;
        unique case (req_q.kind)
          KIND_WAIT: begin
            st_d = ST_FULL;
            if (req_q.node_ok && ncnt_q != CntW'(QUEUE_SLOTS)) begin
              mem_we    = 1'b1;
              mem_waddr = {nidx, ncnt_q[SIdxW-1:0]};
              cnt_inc   = 1'b1;
              st_d      = ST_QUEUED;
            end
          end
          KIND_LEAVE: begin
            occ_clr = req_q.node_ok;
            st_d    = ST_LEFT;
          end
          KIND_DISPATCH: begin
            if (req_q.node_ok && !occ_q[nidx] && ncnt_q != '0) begin
              mem_re    = 1'b1;
              mem_raddr = {nidx, SIdxW'(0)};
              best_d    = '0;
              idx_d     = SIdxW'(1);
              state_d   = BK_SCAN;
            end
          end
          default: ;
        endcase
      end
      BK_SCAN: begin
        // rd_data_q holds entry idx_q-1; compare and fetch the next one
        if (idx_q == SIdxW'(1) || rd_data_q[WeightW-1:0] < bestw_q) begin
          bestw_d = rd_data_q[WeightW-1:0];
          who_d   = rd_data_q[TravW+WeightW-1:WeightW];
          best_d  = idx_q - 1'b1;
        end
        if (!sched_mode_i || {1'b0, idx_q} >= ncnt_q || idx_q == '0) begin
          idx_d = (!sched_mode_i || idx_q == SIdxW'(1)) ? SIdxW'(0) : best_d;
          if (!sched_mode_i) begin
            idx_d   = '0;
            who_d   = rd_data_q[TravW+WeightW-1:WeightW];
          end
          mem_re    = 1'b1;
          mem_raddr = {nidx, idx_d + SIdxW'(1)};
          occ_set = 1'b1;
          st_d    = ST_GRANTED;
          state_d = BK_SHIFT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = {nidx, idx_q};
          idx_d     = idx_q + 1'b1;
        end
      end
      BK_SHIFT: begin
        // rd_data_q holds entry idx_q+1; move it down
        if ({1'b0, idx_q} + CntW'(1) < ncnt_q) begin
          mem_we    = 1'b1;
          mem_waddr = {nidx, idx_q};
          mem_wdata = rd_data_q;
          idx_d     = idx_q + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = {nidx, idx_q + SIdxW'(2)};
        end else begin
          cnt_dec = 1'b1;
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!obusy_q || m_tready_i) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      obusy_q <= 1'b0;
      for (int i = 0; i < NODE_COUNT; i++) begin
        cnt_q[i] <= '0;
        occ_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) obusy_q <= 1'b1;
      else if (m_tready_i) obusy_q <= 1'b0;
      if (cnt_inc) cnt_q[nidx] <= ncnt_q + 1'b1;
      if (cnt_dec) cnt_q[nidx] <= ncnt_q - 1'b1;
      if (occ_set) occ_q[nidx] <= 1'b1;
      if (occ_clr) occ_q[nidx] <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (req_pop_o) req_q <= req_i;
    ncnt_q  <= cnt_q[(state_q == BK_IDLE) ? NIdxW'(req_i.node) : nidx];
    idx_q   <= idx_d;
    best_q  <= best_d;
    bestw_q <= bestw_d;
    who_q   <= who_d;
    st_q    <= st_d;
    if (out_load) m_tdata_o <= {4'd0, req_q.node, who_q, st_q};
  end

  // List memory ports
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_q <= mem_q[mem_raddr];
  end

  assign m_tvalid_o = obusy_q;

endmodule

>>> rtl/node_queue_fcfs_sjf_dispatcher_top.sv
// ----------------------------------------------------------------------------
// node_queue_fcfs_sjf_dispatcher_top: FCFS / SJF node queue dispatcher
// Front intake FIFO feeding a single sequential list engine shared by all nodes.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tuser: kind; tdata: traveler, node, edge_weight
// m_axis    out  status, granted_traveler, result_node
// cfg       in   sched_mode
// A wait, leave or refused dispatch passes through the read and output states of the back engine.
// A grant also scans the list (every entry in SJF mode, only the head in FCFS mode), then
// shifts the later entries of the list down through the list memory before the result is output.
// Reset clears counts and occupants at once; list memory needs no clear.
// The front FIFO keeps taking requests while the engine or output stalls, until it is full.
module node_queue_fcfs_sjf_dispatcher_top #(
  parameter int unsigned NODE_COUNT  = 32,
  parameter int unsigned QUEUE_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // traveler[3:0] node[8:4] edge_weight[24:9]
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status[2:0] granted_traveler[6:3] result_node[11:7]
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);
  import nqd_pkg::*;

  logic  sched_mode_q;
  logic  req_valid, req_pop;
  req_t  req;

  // Hold the mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      sched_mode_q <= cfg_wdata_i;
    end
  end

  nqd_front #(.NODE_COUNT(NODE_COUNT), .FIFO_DEPTH(2)) u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata[24:0]),
    .s_tuser_i  (s_axis_tuser),
    .req_valid_o(req_valid),
    .req_pop_i  (req_pop),
    .req_o      (req)
  );

  nqd_back #(.NODE_COUNT(NODE_COUNT), .QUEUE_SLOTS(QUEUE_SLOTS)) u_back (
    .clk_i, .rst_ni,
    .sched_mode_i(sched_mode_q),
    .req_valid_i (req_valid),
    .req_pop_o   (req_pop),
    .req_i       (req),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

>>> dv/node_queue_fcfs_sjf_dispatcher_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_queue_fcfs_sjf_dispatcher_top_tb: node queue dispatcher testbench
// Drives wait, leave and dispatch requests in both scheduling modes, keeps a
// model of the per-node lists and occupants, and checks every result in order.
// ----------------------------------------------------------------------------
module node_queue_fcfs_sjf_dispatcher_top_tb;
  import nqd_pkg::*;

  localparam int unsigned NODES = 32;
  localparam int unsigned SLOTS = 16;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [TravW-1:0] who;
    status_e          status;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;

  // Model state
  logic             sjf_mode;
  logic [TravW-1:0]   list_ids[NODES][SLOTS];
  logic [WeightW-1:0] list_wts[NODES][SLOTS];
  int unsigned        list_len[NODES];
  logic               occupied[NODES];

  outcome_t pending_outcomes[$];
  int       errors = 0;
  longint   cycles = 0;
  int       nodes_hot;

  node_queue_fcfs_sjf_dispatcher_top uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("node_queue_fcfs_sjf_dispatcher_top test failed");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("ERROR @%0t: %s", $realtime, what);
  endtask

  // Work out the outcome of one request and advance the model
  function automatic outcome_t dispatch_outcome(kind_e k, logic [TravW-1:0] t,
                                                logic [NodeW-1:0] n,
                                                logic [WeightW-1:0] w);
    outcome_t o;
    int best;
    o.status = ST_NONE;
    o.who = t;
    o.node = n;
    case (k)
      KIND_WAIT: begin
        o.status = ST_FULL;
        if (list_len[n] < SLOTS) begin
          list_ids[n][list_len[n]] = t;
          list_wts[n][list_len[n]] = w;
          list_len[n]++;
          o.status = ST_QUEUED;
        end
      end
      KIND_LEAVE: begin
        occupied[n] = 1'b0;
        o.status = ST_LEFT;
      end
      KIND_DISPATCH: begin
        if (!occupied[n] && list_len[n] > 0) begin
          best = 0;
          if (sjf_mode)
            for (int i = 1; i < list_len[n]; i++)
              if (list_wts[n][i] < list_wts[n][best]) best = i;
          o.who = list_ids[n][best];
          occupied[n] = 1'b1;
          for (int i = best; i + 1 < list_len[n]; i++) begin
            list_ids[n][i] = list_ids[n][i+1];
            list_wts[n][i] = list_wts[n][i+1];
          end
          list_len[n]--;
          o.status = ST_GRANTED;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Send one request, holding valid until accepted
  task automatic send_request(kind_e k, logic [TravW-1:0] t, logic [NodeW-1:0] n,
                              logic [WeightW-1:0] w);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= k;
    s_axis_tdata <= {7'b0, w, n, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_outcomes.push_back(dispatch_outcome(k, t, n, w));
  endtask

  task automatic pause_sender();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  // Drain, settle, then write the mode register
  task automatic set_mode(logic m);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sjf_mode = m;
  endtask

  // Receiver stalls in its own pattern, with calm stretches
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else if (cycles % 1000 < 300) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    outcome_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = outcome_t'(m_axis_tdata[11:0]);
      if (pending_outcomes.size() == 0) begin
        report($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        want = pending_outcomes.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d want %0d", got.status, want.status));
        if (got.who !== want.who)
          report($sformatf("traveler %0d want %0d", got.who, want.who));
        if (got.node !== want.node)
          report($sformatf("node %0d want %0d", got.node, want.node));
      end
    end
  end

  task automatic test_directed();
    send_request(KIND_DISPATCH, 4'd3, 5'd0, 16'd0);   // empty node
    send_request(KIND_LEAVE, 4'd15, 5'd31, 16'hFFFF); // leave a free node
    send_request(KIND_UNUSED, 4'd9, 5'd7, 16'h1234);
    for (int i = 0; i < 17; i++)                      // fill past full
      send_request(KIND_WAIT, 4'(i), 5'd31, 16'(16'hFFFF - i * 4097));
    send_request(KIND_DISPATCH, 4'd0, 5'd31, 16'd0);
    send_request(KIND_DISPATCH, 4'd0, 5'd31, 16'd0);  // occupied node
    send_request(KIND_LEAVE, 4'd1, 5'd31, 16'd0);     // non-occupant leaves
    send_request(KIND_DISPATCH, 4'd0, 5'd31, 16'd0);
  endtask

  task automatic test_sjf_ties();
    send_request(KIND_WAIT, 4'd1, 5'd2, 16'd50);
    send_request(KIND_WAIT, 4'd2, 5'd2, 16'd0);
    send_request(KIND_WAIT, 4'd3, 5'd2, 16'd0);
    send_request(KIND_DISPATCH, 4'd0, 5'd2, 16'd0);
    send_request(KIND_LEAVE, 4'd2, 5'd2, 16'd0);
    send_request(KIND_DISPATCH, 4'd0, 5'd2, 16'd0);
  endtask

  // Mostly wait/dispatch/leave traffic, most requests on the lowest nodes_hot nodes
  task automatic test_random(int count);
    int r;
    kind_e k;
    logic [NodeW-1:0] n;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      k = r < 45 ? KIND_WAIT : r < 75 ? KIND_DISPATCH : r < 97 ? KIND_LEAVE : KIND_UNUSED;
      n = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, nodes_hot - 1)) : 5'($urandom);
      send_request(k, 4'($urandom), n,
                   ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom));
      if ($urandom_range(0, 7) == 0 && cycles % 3000 > 800) pause_sender();
    end
  endtask

  initial begin
    sjf_mode = 1'b0;
    foreach (list_len[i]) begin
      list_len[i] = 0;
      occupied[i] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_mode(1'b0);
    test_directed();
    set_mode(1'b1);
    test_directed();
    test_sjf_ties();
    nodes_hot = 3;
    test_random(700);
    set_mode(1'b0);
    nodes_hot = 6;
    test_random(700);
    set_mode(1'b1);
    nodes_hot = 32;
    test_random(600);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("node_queue_fcfs_sjf_dispatcher_top test passed");
    else $display("node_queue_fcfs_sjf_dispatcher_top test failed");
    $finish;
  end

endmodule
